/* src/cpfm_pkg.sv */
// Package for the capture period / frequency meter.
// Holds widths, command and register codes, constants and the control structs.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package cpfm_pkg;

  localparam int CMD_W      = 2;
  localparam int COUNT_W    = 16;
  localparam int STAMP_W    = 2 * COUNT_W;
  localparam int CLK_W      = 32;
  localparam int PRESCALE_W = 9;
  localparam int TICKS_W    = STAMP_W + PRESCALE_W;
  localparam int NS_W       = 30;
  localparam int PROD_W     = TICKS_W + NS_W;
  localparam int PERIOD_W   = 32;
  localparam int FREQ_W     = 30;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  localparam int MUL_STEPS  = NS_W;
  localparam int PDIV_STEPS = PROD_W;
  localparam int FDIV_STEPS = NS_W;
  localparam int STEP_W     = 7;

  localparam logic [NS_W-1:0] NS_PER_SEC = 30'd1000000000;

  localparam logic [CMD_W-1:0] CMD_TICK    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CAPTURE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_ACK     = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_CLOCK_RATE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_PRESCALE   = 1'b1;

  localparam logic [CLK_W-1:0]      CLOCK_RATE_RESET = 32'd24000000;
  localparam logic [PRESCALE_W-1:0] PRESCALE_RESET   = 9'd1;

  // controller -> datapath
  typedef struct packed {
    logic bump_overflow;
    logic load_first;
    logic load_diff;
    logic load_ticks;
    logic mul_load;
    logic mul_step;
    logic div_load_period;
    logic div_load_freq;
    logic div_step;
    logic save_period;
    logic load_out;
    logic fresh;
  } cpfm_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic later_greater;
    logic period_zero;
  } cpfm_status_t;

endpackage

/* src/cpfm_div.sv */
// Shared restoring divider, one quotient bit per step.
// Dividend is loaded left-aligned; overflow flags quotient bits above 32.
// Depends on cpfm_pkg.
`timescale 1ns / 1ps

module cpfm_div
  import cpfm_pkg::*;
(
  input  logic                clk,
  input  logic                load,
  input  logic                step,
  input  logic [PROD_W-1:0]   dividend,
  input  logic [PERIOD_W-1:0] divisor,
  output logic [PERIOD_W-1:0] quotient,
  output logic                overflow
);

  logic [PROD_W-1:0]   dvd;
  logic [PERIOD_W-1:0] dvs;
  logic [PERIOD_W-1:0] rem;
  logic [PERIOD_W:0]   rem_sh;
  logic                ge;

  assign rem_sh = {rem, dvd[PROD_W-1]};
  assign ge     = rem_sh >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (load) begin
      dvd      <= dividend;
      dvs      <= divisor;
      rem      <= '0;
      quotient <= '0;
      overflow <= 1'b0;
    end else if (step) begin
      dvd      <= {dvd[PROD_W-2:0], 1'b0};
      rem      <= ge ? PERIOD_W'(rem_sh - {1'b0, dvs}) : PERIOD_W'(rem_sh);
      quotient <= {quotient[PERIOD_W-2:0], ge};
      // a set bit leaving the top means the quotient does not fit
      overflow <= overflow | quotient[PERIOD_W-1];
    end
  end

endmodule

/* src/cpfm_dp.sv */
// Datapath: configuration registers, wrap counter, capture timestamps,
// serial multiply by one billion, shared divider and the output register.
// Depends on cpfm_pkg and cpfm_div.
`timescale 1ns / 1ps

module cpfm_dp
  import cpfm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [COUNT_W-1:0]    captured_count,
  input  cpfm_cmd_t             cmd,
  output cpfm_status_t          status,
  output logic [PERIOD_W-1:0]   period_ns,
  output logic [FREQ_W-1:0]     freq_hz,
  output logic                  fresh,
  output logic                  zero_period
);

  logic [CLK_W-1:0]      clock_rate;
  logic [PRESCALE_W-1:0] prescale;
  logic [COUNT_W-1:0]    overflow_count;
  logic [STAMP_W-1:0]    first_capture;
  logic [PERIOD_W-1:0]   last_period;
  logic [STAMP_W-1:0]    diff;
  logic [TICKS_W-1:0]    ticks;
  logic [PROD_W-1:0]     acc;
  logic [NS_W-1:0]       ns_sh;
  logic [STAMP_W-1:0]    stamp;
  logic                  div_load;
  logic [PROD_W-1:0]     div_dividend;
  logic [PERIOD_W-1:0]   div_divisor;
  logic [PERIOD_W-1:0]   div_q;
  logic                  div_ovf;

  assign stamp                = {overflow_count, captured_count};
  assign status.later_greater = first_capture < stamp;
  assign status.period_zero   = last_period == '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      clock_rate     <= CLOCK_RATE_RESET;
      prescale       <= PRESCALE_RESET;
      overflow_count <= '0;
      first_capture  <= '0;
      last_period    <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_CLOCK_RATE: clock_rate <= cfg_data[CLK_W-1:0];
          REG_PRESCALE:   prescale   <= cfg_data[PRESCALE_W-1:0];
          default: ;
        endcase
      end
      if (cmd.bump_overflow) overflow_count <= overflow_count + 1'b1;
      if (cmd.load_first)    first_capture  <= stamp;
      // saturate when the quotient needs more than 32 bits
      if (cmd.save_period)   last_period    <= div_ovf ? '1 : div_q;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_diff)  diff  <= stamp - first_capture;
    if (cmd.load_ticks) ticks <= TICKS_W'(diff) * TICKS_W'(prescale);
    if (cmd.mul_load) begin
      acc   <= '0;
      ns_sh <= NS_PER_SEC;
    end else if (cmd.mul_step) begin
      acc   <= {acc[PROD_W-2:0], 1'b0} + (ns_sh[NS_W-1] ? PROD_W'(ticks) : '0);
      ns_sh <= {ns_sh[NS_W-2:0], 1'b0};
    end
    if (cmd.load_out) begin
      period_ns   <= last_period;
      freq_hz     <= status.period_zero ? '0 : div_q[FREQ_W-1:0];
      fresh       <= cmd.fresh;
      zero_period <= status.period_zero;
    end
  end

  assign div_load     = cmd.div_load_period | cmd.div_load_freq;
  assign div_dividend = cmd.div_load_freq ? {NS_PER_SEC, {TICKS_W{1'b0}}} : acc;
  assign div_divisor  = cmd.div_load_freq ? last_period : clock_rate;

  cpfm_div u_div (
    .clk      (clk),
    .load     (div_load),
    .step     (cmd.div_step),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_q),
    .overflow (div_ovf)
  );

endmodule

/* src/cpfm_ctrl.sv */
// Controller: decodes input items, tracks pairing and pending result,
// sequences multiply and divide steps, and drives the output handshake.
// Depends on cpfm_pkg.
`timescale 1ns / 1ps

module cpfm_ctrl
  import cpfm_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  input  logic [CMD_W-1:0] command,
  output logic             s_tready,
  output logic             m_tvalid,
  input  logic             m_tready,
  output cpfm_cmd_t        cmd,
  input  cpfm_status_t     status
);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_TICKS  = 4'd1;
  localparam logic [3:0] ST_MUL    = 4'd2;
  localparam logic [3:0] ST_PLOAD  = 4'd3;
  localparam logic [3:0] ST_DIVP   = 4'd4;
  localparam logic [3:0] ST_SAVE   = 4'd5;
  localparam logic [3:0] ST_FSTART = 4'd6;
  localparam logic [3:0] ST_DIVF   = 4'd7;
  localparam logic [3:0] ST_OUT    = 4'd8;

  logic [3:0]        state, state_next;
  logic [STEP_W-1:0] cnt, cnt_next;
  logic              awaiting, awaiting_next;
  logic              pending, pending_next;
  logic              fresh, fresh_next;
  logic              m_tvalid_next;

  assign s_tready = state == ST_IDLE;

  always_comb begin
    state_next    = state;
    cnt_next      = cnt;
    awaiting_next = awaiting;
    pending_next  = pending;
    fresh_next    = fresh;
    m_tvalid_next = m_tvalid && !m_tready;
    cmd           = '0;
    cmd.fresh     = fresh;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          case (command)
            CMD_TICK: cmd.bump_overflow = 1'b1;
            CMD_ACK:  pending_next = 1'b0;
            CMD_CAPTURE: begin
              // drop captures until the last result is acknowledged
              if (!pending) begin
                if (!awaiting) begin
                  cmd.load_first = 1'b1;
                  awaiting_next  = 1'b1;
                end else begin
                  awaiting_next = 1'b0;
                  pending_next  = 1'b1;
                  if (status.later_greater) begin
                    cmd.load_diff = 1'b1;
                    fresh_next    = 1'b1;
                    state_next    = ST_TICKS;
                  end else begin
                    fresh_next = 1'b0;
                    state_next = ST_FSTART;
                  end
                end
              end
            end
            default: ;
          endcase
        end
      end
      ST_TICKS: begin
        cmd.load_ticks = 1'b1;
        cmd.mul_load   = 1'b1;
        cnt_next       = '0;
        state_next     = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul_step = 1'b1;
        cnt_next     = cnt + 1'b1;
        if (cnt == STEP_W'(MUL_STEPS - 1)) state_next = ST_PLOAD;
      end
      ST_PLOAD: begin
        cmd.div_load_period = 1'b1;
        cnt_next            = '0;
        state_next          = ST_DIVP;
      end
      ST_DIVP: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt + 1'b1;
        if (cnt == STEP_W'(PDIV_STEPS - 1)) state_next = ST_SAVE;
      end
      ST_SAVE: begin
        cmd.save_period = 1'b1;
        state_next      = ST_FSTART;
      end
      ST_FSTART: begin
        if (status.period_zero) begin
          state_next = ST_OUT;
        end else begin
          cmd.div_load_freq = 1'b1;
          cnt_next          = '0;
          state_next        = ST_DIVF;
        end
      end
      ST_DIVF: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt + 1'b1;
        if (cnt == STEP_W'(FDIV_STEPS - 1)) state_next = ST_OUT;
      end
      ST_OUT: begin
        // hold until the output register is free
        if (!m_tvalid || m_tready) begin
          cmd.load_out  = 1'b1;
          m_tvalid_next = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      cnt      <= '0;
      awaiting <= 1'b0;
      pending  <= 1'b0;
      fresh    <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      cnt      <= cnt_next;
      awaiting <= awaiting_next;
      pending  <= pending_next;
      fresh    <= fresh_next;
      m_tvalid <= m_tvalid_next;
    end
  end

endmodule

/* src/capture_period_frequency_meter.sv */
// Capture period / frequency meter. An overflow tick or an acknowledge item
// is taken in the idle state. The second capture of a pair starts a
// computation (a latch of the difference, one 32x9 multiply, 30 shift-add
// steps by one billion, 71 steps of the shared bit-serial divider for the
// period and 30 more for the frequency); s_tready stays low during it. The
// result sits in an output register, so input items are taken while it
// waits for m_tready. Captures arriving while a result is unacknowledged
// are dropped. The period saturates at 2^32-1; a zero period gives zero
// frequency with the zero_period flag.
`timescale 1ns / 1ps

module capture_period_frequency_meter
  import cpfm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [15:0]           s_tdata,  // [15:0] captured_count
  input  logic [CMD_W-1:0]      s_tuser,  // [1:0] command
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [63:0]           m_tdata,  // [31:0] period_ns, [61:32] freq_hz, zero pad
  output logic [1:0]            m_tuser   // [0] fresh, [1] zero_period
);

  cpfm_cmd_t           cmd;
  cpfm_status_t        status;
  logic [PERIOD_W-1:0] period_ns;
  logic [FREQ_W-1:0]   freq_hz;
  logic                fresh;
  logic                zero_period;

  cpfm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .command  (s_tuser),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd),
    .status   (status)
  );

  cpfm_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .captured_count (s_tdata[COUNT_W-1:0]),
    .cmd            (cmd),
    .status         (status),
    .period_ns      (period_ns),
    .freq_hz        (freq_hz),
    .fresh          (fresh),
    .zero_period    (zero_period)
  );

  assign m_tdata = {2'b00, freq_hz, period_ns};
  assign m_tuser = {zero_period, fresh};

endmodule
